// ===== hdl/tdf_pkg.sv =====
// ---------------------------------------------------------------------------
// tdf_pkg
// Types and constants shared by the timestamp drift filter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdf_pkg;

	localparam int TS_W     = 64;
	localparam int CNT_W    = 10;
	localparam int PERIOD_W = 30;
	localparam int TOL_W    = 40;
	localparam int PHASE_W  = 16;
	localparam int RATIO_W  = 48;
	localparam int STAT_W   = 3;
	localparam int STEP_W   = RATIO_W + PERIOD_W;   // ratio * period, Q.frac ns
	localparam int ERR_W    = TOL_W + 1;            // signed error, |err| <= tolerance
	localparam int TMAG_W   = 46;                   // |21*err - 20*last_err|
	localparam int MA_W     = 80;                   // multiplier A operand
	localparam int MB_W     = 32;                   // multiplier B operand, one bit a cycle
	localparam int MN_W     = 6;
	localparam int PW       = MA_W + MB_W;
	localparam int NUM_W    = 128;                  // divider numerator, one bit a cycle
	localparam int DEN_W    = 80;
	localparam int DN_W     = 8;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;

	localparam logic [TS_W-1:0]    I64_MAX   = {1'b0, {(TS_W-1){1'b1}}};
	localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
	localparam logic [MB_W-1:0]    SKIP_MAX  = 32'h8000_0000;

	// register indexes (byte address / 8)
	localparam logic [2:0] REG_ENABLED = 3'd0;
	localparam logic [2:0] REG_PERIOD  = 3'd1;
	localparam logic [2:0] REG_TOL     = 3'd2;
	localparam logic [2:0] REG_PHASE   = 3'd3;
	localparam logic [2:0] REG_GAIN    = 3'd4;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_BAD    = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_FIRST   = 3'd0,
		ST_RECOVER = 3'd1,
		ST_TOLRST  = 3'd2,
		ST_FILTER  = 3'd3,
		ST_BADREAD = 3'd4,
		ST_ERROR   = 3'd5
	} tdf_status_t;

	typedef enum logic [1:0] {
		MS_STEP,
		MS_PRED,
		MS_ADV,
		MS_TERR
	} tdf_mul_sel_t;

	typedef enum logic [1:0] {
		DS_SKIP,
		DS_PHASE,
		DS_GAIN
	} tdf_div_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECIDE,
		S_STEP,
		S_STEP_W,
		S_SPLIT,
		S_KDIV,
		S_KDIV_W,
		S_ADV,
		S_ADV_W,
		S_PRED,
		S_PRED_W,
		S_CHECK,
		S_PHDIV,
		S_PHDIV_W,
		S_TMUL,
		S_TMUL_W,
		S_GDIV,
		S_GDIV_W,
		S_FIN
	} tdf_state_t;

	typedef struct packed {
		logic                cmd;
		logic signed [TS_W-1:0] timestamp_ns;
		logic [CNT_W-1:0]    sample_count;
	} tdf_in_t;

	typedef struct packed {
		logic signed [TS_W-1:0] filtered_ns;
		logic [STAT_W-1:0]   status;
	} tdf_out_t;

	typedef struct packed {
		logic                enabled;
		logic [PERIOD_W-1:0] expected_period_ns;
		logic [TOL_W-1:0]    tol_limit_ns;
		logic [PHASE_W-1:0]  phase_divisor;
		logic [RATIO_W-1:0]  ratio_gain_divisor;
	} tdf_cfg_t;

	typedef struct packed {
		logic         cap;
		logic         mul_start;
		tdf_mul_sel_t mul_sel;
		logic         div_start;
		tdf_div_sel_t div_sel;
		logic         step_ld;
		logic         k_ld;
		logic         pred_ld;
		logic         ph_ld;
		logic         fin;
		tdf_status_t  kind;
	} tdf_cmd_t;

	typedef struct packed {
		logic enabled;
		logic bad_cmd;
		logic cnt_zero;
		logic first;
		logic bad_read;
		logic skip_ok;
		logic over_tol;
		logic mul_done;
		logic div_done;
	} tdf_sts_t;

endpackage

// ===== hdl/timestamp_drift_filter.sv =====
// ---------------------------------------------------------------------------
// timestamp_drift_filter
// Smooths periodic sensor timestamps and tracks the sensor clock ratio.
// ---------------------------------------------------------------------------
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_ready   | tdf_in_t  (cmd, timestamp_ns, sample_count)
// out     | output    | out_valid/out_ready | tdf_out_t (filtered_ns, status)
// cfg     | input     | APB psel/penable    | 64-bit registers at 8*index
//
// One item at a time. Error, bad-read and first items go straight to the
// result. Tolerance resets and recoveries use the serial multiplier;
// filtered items and recoveries that compute a skip count also use the
// one-bit-per-cycle divider. A finished result waits in the output
// register; the next item is taken meanwhile and stalls only at its own
// end if the result is still unread. Reset clears the filter state and
// loads the register defaults.
`timescale 1ns / 1ps

module timestamp_drift_filter #(
	parameter int RATIO_FRAC_BITS = 40
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tdf_pkg::tdf_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tdf_pkg::tdf_out_t            out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tdf_pkg::ADDR_W-1:0]   paddr,
	input  logic [tdf_pkg::DATA_W-1:0]   pwdata,
	output logic [tdf_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import tdf_pkg::*;

	tdf_cfg_t   cfg_q;
	tdf_cmd_t   cmd;
	tdf_sts_t   sts;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled            <= 1'b0;
			cfg_q.expected_period_ns <= PERIOD_W'(1000000);
			cfg_q.tol_limit_ns       <= TOL_W'(5000000);
			cfg_q.phase_divisor      <= PHASE_W'(10);
			cfg_q.ratio_gain_divisor <= RATIO_W'(64'd1000000000000);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLED: cfg_q.enabled            <= pwdata[0];
				REG_PERIOD:  cfg_q.expected_period_ns <= pwdata[PERIOD_W-1:0];
				REG_TOL:     cfg_q.tol_limit_ns       <= pwdata[TOL_W-1:0];
				REG_PHASE:   cfg_q.phase_divisor      <= pwdata[PHASE_W-1:0];
				REG_GAIN:    cfg_q.ratio_gain_divisor <= pwdata[RATIO_W-1:0];
				default:     cfg_q.enabled            <= cfg_q.enabled;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ENABLED: prdata = DATA_W'(cfg_q.enabled);
			REG_PERIOD:  prdata = DATA_W'(cfg_q.expected_period_ns);
			REG_TOL:     prdata = DATA_W'(cfg_q.tol_limit_ns);
			REG_PHASE:   prdata = DATA_W'(cfg_q.phase_divisor);
			REG_GAIN:    prdata = DATA_W'(cfg_q.ratio_gain_divisor);
			default:     prdata = '0;
		endcase
	end

	tdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tdf_dp #(
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.in_data  (in_data),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

// ===== hdl/tdf_mul.sv =====
// ---------------------------------------------------------------------------
// tdf_mul
// Shift-add multiplier, one bit of the B operand per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdf_mul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [tdf_pkg::MA_W-1:0] a,
	input  logic [tdf_pkg::MB_W-1:0] b,
	input  logic [tdf_pkg::MN_W-1:0] n,
	output logic                   done,
	output logic [tdf_pkg::PW-1:0] prod
);
	import tdf_pkg::*;

	logic [PW-1:0]   acc_q;
	logic [PW-1:0]   a_q;
	logic [MB_W-1:0] b_q;
	logic [MN_W-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= PW'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== hdl/tdf_div.sv =====
// ---------------------------------------------------------------------------
// tdf_div
// Restoring divider, one quotient bit per cycle. The numerator arrives
// left-aligned; n is the number of significant numerator bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tdf_pkg::NUM_W-1:0] num,
	input  logic [tdf_pkg::DEN_W-1:0] den,
	input  logic [tdf_pkg::DN_W-1:0]  n,
	output logic                      done,
	output logic [tdf_pkg::NUM_W-1:0] quot,
	output logic [tdf_pkg::DEN_W-1:0] rem
);
	import tdf_pkg::*;

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DN_W-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   sh;
	logic             fit;

	assign sh  = {rem_q, num_q[NUM_W-1]};
	assign fit = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_W-2:0], fit};
			if (fit) begin
				rem_q <= DEN_W'(sh - {1'b0, den_q});
			end else begin
				rem_q <= sh[DEN_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/tdf_dp.sv =====
// ---------------------------------------------------------------------------
// tdf_dp
// Filter datapath: filter state, operand selection for the shared
// multiplier and divider, saturation and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdf_dp #(
	parameter int RATIO_FRAC_BITS = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tdf_pkg::tdf_cmd_t  cmd,
	input  tdf_pkg::tdf_cfg_t  cfg,
	input  tdf_pkg::tdf_in_t   in_data,
	output tdf_pkg::tdf_sts_t  sts,
	output tdf_pkg::tdf_out_t  out_data
);
	import tdf_pkg::*;

	localparam int KN_W = TS_W + RATIO_FRAC_BITS + 2;
	localparam int GN_W = TMAG_W + CNT_W + RATIO_FRAC_BITS + 2;
	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

	// item and state
	logic                    cmd_q;
	logic signed [TS_W-1:0]  ts_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [TS_W-1:0]  last_stamp_q;
	logic signed [ERR_W-1:0] last_err_q;
	logic [RATIO_W-1:0]      ratio_q;
	logic                    bad_read_q;
	logic [STEP_W-1:0]       step_q;
	logic [MB_W-1:0]         k_q;
	logic signed [TS_W-1:0]  pred_q;
	logic signed [TS_W-1:0]  filt_q;
	tdf_out_t                out_q;

	// units
	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic [MN_W-1:0]  mul_n;
	logic             mul_done;
	logic [PW-1:0]    prod;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [DN_W-1:0]  div_n;
	logic             div_done;
	logic [NUM_W-1:0] quot;
	logic [DEN_W-1:0] rem;

	// combinational
	logic                    first;
	logic [TS_W-1:0]         delta;
	logic                    skip_ok;
	logic                    ge;
	logic [TS_W-1:0]         mag;
	logic                    over_tol;
	logic [PHASE_W-1:0]      phase_eff;
	logic [RATIO_W-1:0]      gain_eff;
	logic [PW-1:0]           adv;
	logic [TS_W-1:0]         lim;
	logic signed [TS_W-1:0]  pred_d;
	logic [NUM_W-1:0]        num_k;
	logic [NUM_W-1:0]        num_g;
	logic [MB_W-1:0]         k_d;
	logic [TS_W-1:0]         qmag;
	logic signed [TS_W-1:0]  qs;
	logic signed [TS_W-1:0]  sum_f;
	logic                    rnz;
	logic signed [TS_W-1:0]  filt_d;
	logic signed [47:0]      d_ext;
	logic signed [47:0]      le_ext;
	logic signed [47:0]      terr;
	logic signed [47:0]      tabs;
	logic                    tneg;
	logic [TMAG_W-1:0]       tmag;
	logic [RATIO_W-1:0]      up_lim;
	logic [RATIO_W-1:0]      ratio_d;

	assign first     = last_stamp_q[TS_W-1] || (last_stamp_q == '0);
	assign delta     = $unsigned(ts_q) - $unsigned(last_stamp_q);
	assign skip_ok   = (ts_q > last_stamp_q) && (step_q != '0);
	assign ge        = ts_q >= pred_q;
	assign mag       = ge ? ($unsigned(ts_q) - $unsigned(pred_q))
	                      : ($unsigned(pred_q) - $unsigned(ts_q));
	assign over_tol  = mag > TS_W'(cfg.tol_limit_ns);
	assign phase_eff = (cfg.phase_divisor == '0) ? PHASE_W'(1) : cfg.phase_divisor;
	assign gain_eff  = (cfg.ratio_gain_divisor == '0) ? RATIO_W'(1) : cfg.ratio_gain_divisor;

	// last + (product >> frac), saturated at the largest positive stamp
	assign adv    = prod >> RATIO_FRAC_BITS;
	assign lim    = I64_MAX - $unsigned(last_stamp_q);
	assign pred_d = (adv > PW'(lim)) ? $signed(I64_MAX)
	                                 : $signed($unsigned(last_stamp_q) + adv[TS_W-1:0]);

	// PD term
	assign d_ext  = ge ? $signed({8'b0, mag[TOL_W-1:0]}) : -$signed({8'b0, mag[TOL_W-1:0]});
	assign le_ext = 48'(last_err_q);
	assign terr   = d_ext * 48'sd21 - le_ext * 48'sd20;
	assign tneg   = terr[47];
	assign tabs   = tneg ? -terr : terr;
	assign tmag   = tabs[TMAG_W-1:0];

	always_comb begin
		case (cmd.mul_sel)
			MS_STEP: begin
				mul_a = MA_W'(ratio_q);
				mul_b = MB_W'(cfg.expected_period_ns);
				mul_n = MN_W'(PERIOD_W);
			end
			MS_PRED: begin
				mul_a = MA_W'(step_q);
				mul_b = MB_W'(cnt_q);
				mul_n = MN_W'(CNT_W);
			end
			MS_ADV: begin
				mul_a = MA_W'(step_q);
				mul_b = k_q;
				mul_n = MN_W'(MB_W);
			end
			default: begin
				mul_a = MA_W'(tmag);
				mul_b = MB_W'(cnt_q);
				mul_n = MN_W'(CNT_W);
			end
		endcase
	end

	assign num_k = (NUM_W'(delta) << (RATIO_FRAC_BITS + 1)) + NUM_W'(step_q);
	assign num_g = (NUM_W'(prod) << (RATIO_FRAC_BITS + 1)) + NUM_W'(gain_eff);

	always_comb begin
		case (cmd.div_sel)
			DS_SKIP: begin
				div_num = num_k << (NUM_W - KN_W);
				div_den = DEN_W'({step_q, 1'b0});
				div_n   = DN_W'(KN_W);
			end
			DS_PHASE: begin
				div_num = NUM_W'(mag) << (NUM_W - TS_W);
				div_den = DEN_W'(phase_eff);
				div_n   = DN_W'(TS_W);
			end
			default: begin
				div_num = num_g << (NUM_W - GN_W);
				div_den = DEN_W'({gain_eff, 1'b0});
				div_n   = DN_W'(GN_W);
			end
		endcase
	end

	tdf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.n      (mul_n),
		.done   (mul_done),
		.prod   (prod)
	);

	tdf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.n      (div_n),
		.done   (div_done),
		.quot   (quot),
		.rem    (rem)
	);

	// skipped periods, rounded, at least one, clamped
	always_comb begin
		if (!skip_ok) begin
			k_d = MB_W'(1);
		end else if (quot > NUM_W'(SKIP_MAX)) begin
			k_d = SKIP_MAX;
		end else if (quot > NUM_W'(1)) begin
			k_d = quot[MB_W-1:0];
		end else begin
			k_d = MB_W'(1);
		end
	end

	// floor division of the error, then truncate the sum toward zero
	assign rnz   = rem != '0;
	assign qmag  = TS_W'(quot[TOL_W-1:0]) + TS_W'(!ge && rnz);
	assign qs    = ge ? $signed(qmag) : -$signed(qmag);
	assign sum_f = pred_q + qs;

	always_comb begin
		if (ge && sum_f[TS_W-1]) begin
			filt_d = $signed(I64_MAX);
		end else if (sum_f[TS_W-1] && rnz) begin
			filt_d = sum_f + 64'sd1;
		end else begin
			filt_d = sum_f;
		end
	end

	assign up_lim = RATIO_MAX - ratio_q;

	always_comb begin
		if (!tneg) begin
			ratio_d = (quot > NUM_W'(up_lim)) ? RATIO_MAX : ratio_q + quot[RATIO_W-1:0];
		end else begin
			ratio_d = (quot >= NUM_W'(ratio_q)) ? '0 : ratio_q - quot[RATIO_W-1:0];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cmd_q <= in_data.cmd;
			ts_q  <= in_data.timestamp_ns;
			cnt_q <= in_data.sample_count;
		end
		if (cmd.step_ld) begin
			step_q <= prod[STEP_W-1:0];
		end
		if (cmd.k_ld) begin
			k_q <= k_d;
		end
		if (cmd.pred_ld) begin
			pred_q <= pred_d;
		end
		if (cmd.ph_ld) begin
			filt_q <= filt_d;
		end
		if (cmd.fin) begin
			out_q.status <= cmd.kind;
			case (cmd.kind)
				ST_FIRST, ST_TOLRST: out_q.filtered_ns <= ts_q;
				ST_RECOVER:          out_q.filtered_ns <= pred_q;
				ST_FILTER:           out_q.filtered_ns <= filt_q;
				ST_BADREAD:          out_q.filtered_ns <= '0;
				default:             out_q.filtered_ns <= '1;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			last_err_q   <= '0;
			ratio_q      <= RATIO_ONE;
			bad_read_q   <= 1'b0;
		end else if (cmd.fin) begin
			case (cmd.kind)
				ST_FIRST, ST_TOLRST: begin
					last_stamp_q <= ts_q;
					last_err_q   <= '0;
					bad_read_q   <= 1'b0;
				end
				ST_RECOVER: begin
					last_stamp_q <= pred_q;
					last_err_q   <= '0;
					bad_read_q   <= 1'b0;
				end
				ST_FILTER: begin
					last_stamp_q <= filt_q;
					last_err_q   <= d_ext[ERR_W-1:0];
					ratio_q      <= ratio_d;
				end
				ST_BADREAD: begin
					bad_read_q <= 1'b1;
				end
				default: begin
					last_stamp_q <= last_stamp_q;
				end
			endcase
		end
	end

	assign sts.enabled  = cfg.enabled;
	assign sts.bad_cmd  = cmd_q == CMD_BAD;
	assign sts.cnt_zero = cnt_q == '0;
	assign sts.first    = first;
	assign sts.bad_read = bad_read_q;
	assign sts.skip_ok  = skip_ok;
	assign sts.over_tol = over_tol;
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;

	assign out_data = out_q;

endmodule

// ===== hdl/tdf_ctrl.sv =====
// ---------------------------------------------------------------------------
// tdf_ctrl
// Sequencer: steps the datapath through one item and owns both handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tdf_pkg::tdf_sts_t sts,
	output tdf_pkg::tdf_cmd_t cmd
);
	import tdf_pkg::*;

	tdf_state_t  state_q, state_d;
	tdf_status_t kind_q, kind_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = S_FIN;
				if (!sts.enabled) begin
					kind_d = ST_ERROR;
				end else if (sts.bad_cmd) begin
					kind_d = ST_BADREAD;
				end else if (sts.cnt_zero) begin
					kind_d = ST_ERROR;
				end else if (sts.first) begin
					kind_d = ST_FIRST;
				end else begin
					state_d = S_STEP;
				end
			end
			S_STEP:   state_d = S_STEP_W;
			S_STEP_W: if (sts.mul_done) state_d = S_SPLIT;
			S_SPLIT: begin
				if (!sts.bad_read) begin
					state_d = S_PRED;
				end else if (sts.skip_ok) begin
					state_d = S_KDIV;
				end else begin
					state_d = S_ADV;
				end
			end
			S_KDIV:   state_d = S_KDIV_W;
			S_KDIV_W: if (sts.div_done) state_d = S_ADV;
			S_ADV:    state_d = S_ADV_W;
			S_ADV_W: begin
				if (sts.mul_done) begin
					state_d = S_FIN;
					kind_d  = ST_RECOVER;
				end
			end
			S_PRED:   state_d = S_PRED_W;
			S_PRED_W: if (sts.mul_done) state_d = S_CHECK;
			S_CHECK: begin
				if (sts.over_tol) begin
					state_d = S_FIN;
					kind_d  = ST_TOLRST;
				end else begin
					state_d = S_PHDIV;
				end
			end
			S_PHDIV:   state_d = S_PHDIV_W;
			S_PHDIV_W: if (sts.div_done) state_d = S_TMUL;
			S_TMUL:    state_d = S_TMUL_W;
			S_TMUL_W:  if (sts.mul_done) state_d = S_GDIV;
			S_GDIV:    state_d = S_GDIV_W;
			S_GDIV_W: begin
				if (sts.div_done) begin
					state_d = S_FIN;
					kind_d  = ST_FILTER;
				end
			end
			S_FIN:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.kind      = kind_q;
		cmd.mul_sel   = MS_STEP;
		cmd.div_sel   = DS_SKIP;
		unique case (state_q)
			S_IDLE:   cmd.cap = in_valid;
			S_STEP:   cmd.mul_start = 1'b1;
			S_STEP_W: cmd.step_ld = sts.mul_done;
			S_SPLIT:  cmd.k_ld = sts.bad_read && !sts.skip_ok;
			S_KDIV:   cmd.div_start = 1'b1;
			S_KDIV_W: cmd.k_ld = sts.div_done;
			S_ADV: begin
				cmd.mul_sel   = MS_ADV;
				cmd.mul_start = 1'b1;
			end
			S_ADV_W: begin
				cmd.mul_sel = MS_ADV;
				cmd.pred_ld = sts.mul_done;
			end
			S_PRED: begin
				cmd.mul_sel   = MS_PRED;
				cmd.mul_start = 1'b1;
			end
			S_PRED_W: begin
				cmd.mul_sel = MS_PRED;
				cmd.pred_ld = sts.mul_done;
			end
			S_PHDIV: begin
				cmd.div_sel   = DS_PHASE;
				cmd.div_start = 1'b1;
			end
			S_PHDIV_W: begin
				cmd.div_sel = DS_PHASE;
				cmd.ph_ld   = sts.div_done;
			end
			S_TMUL: begin
				cmd.mul_sel   = MS_TERR;
				cmd.mul_start = 1'b1;
			end
			S_TMUL_W: cmd.mul_sel = MS_TERR;
			S_GDIV: begin
				cmd.mul_sel   = MS_TERR;
				cmd.div_sel   = DS_GAIN;
				cmd.div_start = 1'b1;
			end
			S_GDIV_W: begin
				cmd.mul_sel = MS_TERR;
				cmd.div_sel = DS_GAIN;
			end
			S_FIN: begin
				cmd.div_sel = DS_GAIN;
				cmd.fin     = out_free;
			end
			default: cmd.cap = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= ST_ERROR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== tb/timestamp_drift_filter_tb.sv =====
// ---------------------------------------------------------------------------
// timestamp_drift_filter_tb
// Self-checking bench: a directed table, then randomized sample streams over
// several register settings. Typed table rows are held to their listed
// values, the rest to a model (stamp, error, Q8.40 clock ratio, bad-read flag).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_drift_filter_tb;
	import tdf_pkg::*;

	localparam int       CYCLE_LIMIT = 4000000;
	localparam int       HOLD_CYCLES = 1500;
	localparam int       SETTLE      = 300;
	localparam int       FRAC        = 40;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		logic        en;
		logic        cmd;
		longint      ts;
		int          cnt;
		bit          typed;
		longint      want_ts;
		tdf_status_t want_st;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tdf_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tdf_out_t out_data;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// filter model state and register copies
	logic signed [63:0] m_stamp, m_err;
	logic [RATIO_W-1:0]  m_ratio;
	logic                m_bad;
	logic                c_en;
	logic [PERIOD_W-1:0] c_period;
	logic [TOL_W-1:0]    c_tol;
	logic [PHASE_W-1:0]  c_phase;
	logic [RATIO_W-1:0]  c_gain;

	tdf_out_t pending[$];
	int  fails = 0;
	int  cycles = 0;
	bit  calm = 1'b0;
	bit  hold_on = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_cnt = 0;

	always #6 clk = ~clk;

	timestamp_drift_filter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	function automatic logic signed [63:0] sat_advance(logic signed [63:0] base,
			logic [127:0] adv);
		if (adv[127:64] != 0 || adv[63:0] > 64'(S64_MAX - base))
			return S64_MAX;
		return base + $signed(adv[63:0]);
	endfunction

	// computes one result and moves the filter model forward
	function automatic tdf_out_t filter_item(tdf_in_t it);
		tdf_out_t o;
		logic signed [63:0] ts, pred, q, filt, diff, t;
		logic [127:0] step, num, kq, dq;
		logic [63:0] delta, mag, k, r0, r, phase, gain, tmag;
		logic [63:0] cnt;
		bit neg, tneg;
		ts = it.timestamp_ns;
		cnt = 64'(it.sample_count);
		o.filtered_ns = -64'sd1;
		o.status = ST_ERROR;
		if (!c_en) return o;
		if (it.cmd == CMD_BAD) begin
			m_bad = 1'b1;
			o.filtered_ns = 0;
			o.status = ST_BADREAD;
			return o;
		end
		if (cnt == 0) return o;
		if (m_stamp <= 0) begin
			m_stamp = ts; m_bad = 1'b0; m_err = 0;
			o.filtered_ns = ts; o.status = ST_FIRST;
			return o;
		end
		step = 128'(m_ratio) * 128'(c_period);
		if (m_bad) begin
			k = 1;
			if (ts > m_stamp && step != 0) begin
				delta = 64'(ts - m_stamp);
				num = (128'(delta) << (FRAC + 1)) + step;
				kq = num / (step << 1);
				if (kq > 128'(SKIP_MAX)) k = 64'(SKIP_MAX);
				else if (kq > 1) k = kq[63:0];
			end
			m_stamp = sat_advance(m_stamp, (step * 128'(k)) >> FRAC);
			m_err = 0; m_bad = 1'b0;
			o.filtered_ns = m_stamp; o.status = ST_RECOVER;
			return o;
		end
		pred = sat_advance(m_stamp, (step * 128'(cnt)) >> FRAC);
		neg = !(ts >= pred);
		mag = neg ? 64'(pred - ts) : 64'(ts - pred);
		if (mag > 64'(c_tol)) begin
			m_stamp = ts; m_err = 0;
			o.filtered_ns = ts; o.status = ST_TOLRST;
			return o;
		end
		diff = neg ? -$signed(mag) : $signed(mag);
		phase = (c_phase == 0) ? 64'd1 : 64'(c_phase);
		r0 = mag % phase;
		if (!neg) begin
			q = $signed(mag / phase); r = r0;
		end else begin
			q = -$signed(mag / phase) - ((r0 != 0) ? 64'sd1 : 64'sd0);
			r = (r0 != 0) ? phase - r0 : 0;
		end
		if (q > 0 && pred > S64_MAX - q) filt = S64_MAX;
		else begin
			filt = pred + q;
			if (filt < 0 && r != 0) filt = filt + 1;
		end
		// PD ratio correction, rounded half away from zero
		t = 64'sd21 * diff - 64'sd20 * m_err;
		tneg = t < 0;
		tmag = tneg ? 64'(-t) : 64'(t);
		gain = (c_gain == 0) ? 64'd1 : 64'(c_gain);
		dq = ((128'(tmag) * 128'(cnt)) << (FRAC + 1)) + 128'(gain);
		dq = dq / (128'(gain) << 1);
		if (!tneg) begin
			if (dq > 128'(RATIO_MAX - m_ratio)) m_ratio = RATIO_MAX;
			else m_ratio = m_ratio + dq[RATIO_W-1:0];
		end else begin
			if (dq >= 128'(m_ratio)) m_ratio = '0;
			else m_ratio = m_ratio - dq[RATIO_W-1:0];
		end
		m_err = diff;
		m_stamp = filt;
		o.filtered_ns = filt; o.status = ST_FILTER;
		return o;
	endfunction

	task automatic reg_write(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 3'b000}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ENABLED: c_en = val[0];
			REG_PERIOD:  c_period = val[PERIOD_W-1:0];
			REG_TOL:     c_tol = val[TOL_W-1:0];
			REG_PHASE:   c_phase = val[PHASE_W-1:0];
			default:     c_gain = val[RATIO_W-1:0];
		endcase
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_filter(logic en, logic [63:0] period, logic [63:0] tol,
			logic [63:0] phase, logic [63:0] gain);
		drain();
		reg_write(REG_ENABLED, 64'(en));
		reg_write(REG_PERIOD, period);
		reg_write(REG_TOL, tol);
		reg_write(REG_PHASE, phase);
		reg_write(REG_GAIN, gain);
	endtask

	// offers one item, waits for acceptance, queues its expected result;
	// valid stays up until the next offer or a drain decides otherwise
	task automatic offer(tdf_in_t it, bit typed, tdf_out_t want);
		tdf_out_t got;
		int idle;
		idle = 0;
		if (!calm) begin
			while ($urandom_range(0, 99) < 34) idle++;
		end
		if (idle != 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		got = filter_item(it);
		pending.push_back(typed ? want : got);
	endtask

	task automatic random_run(int n);
		tdf_in_t it;
		longint amp, base;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			it.cmd = CMD_SAMPLE;
			it.sample_count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(1, 1023))
				: CNT_W'($urandom_range(1, 4));
			if (sel < 10) begin
				it.cmd = CMD_BAD;
				it.timestamp_ns = {$urandom, $urandom};
				it.sample_count = CNT_W'($urandom);
			end else if (sel < 15) begin
				it.sample_count = '0;
				it.timestamp_ns = {$urandom, $urandom};
			end else if (sel < 30) begin
				it.timestamp_ns = {$urandom, $urandom};
			end else begin
				// plausible next stamp: nominal advance plus noise near the tolerance
				amp = (c_tol > 40'd1073741823) ? 64'd1073741823 : 64'(c_tol);
				amp = amp + amp / 4 + 1;
				if (amp > 64'd1073741823) amp = 64'd1073741823;
				base = m_stamp + longint'(it.sample_count) * longint'(c_period);
				if (m_bad) base = base + longint'($urandom_range(0, 7)) * longint'(c_period);
				it.timestamp_ns = base + longint'($urandom_range(0, 2 * amp)) - amp;
			end
			offer(it, 1'b0, '0);
		end
	endtask

	vec_t table_rows[] = '{
		'{1'b0, CMD_SAMPLE, 64'sd5, 1, 1'b1, -64'sd1, ST_ERROR},
		'{1'b0, CMD_BAD, 64'sd9, 3, 1'b1, -64'sd1, ST_ERROR},
		'{1'b1, CMD_SAMPLE, 64'sd1000, 0, 1'b1, -64'sd1, ST_ERROR},
		'{1'b1, CMD_BAD, 64'sd0, 1023, 1'b1, 64'sd0, ST_BADREAD},
		'{1'b1, CMD_SAMPLE, 64'sd1000, 1, 1'b1, 64'sd1000, ST_FIRST},
		'{1'b1, CMD_SAMPLE, 64'sd1001037, 1, 1'b0, 0, ST_ERROR},
		'{1'b1, CMD_SAMPLE, 64'sd3000950, 2, 1'b0, 0, ST_ERROR},
		'{1'b1, CMD_SAMPLE, 64'sd2000000000, 1, 1'b1, 64'sd2000000000, ST_TOLRST},
		'{1'b1, CMD_BAD, -64'sd1, 5, 1'b1, 64'sd0, ST_BADREAD},
		'{1'b1, CMD_SAMPLE, 64'sd2005500000, 1, 1'b0, 0, ST_ERROR},
		'{1'b1, CMD_BAD, 64'sd0, 0, 1'b1, 64'sd0, ST_BADREAD},
		'{1'b1, CMD_SAMPLE, 64'sd7, 1, 1'b0, 0, ST_ERROR},
		'{1'b1, CMD_SAMPLE, 64'sd3029000000, 1023, 1'b0, 0, ST_ERROR},
		'{1'b1, CMD_SAMPLE, S64_MAX, 1, 1'b1, S64_MAX, ST_TOLRST},
		'{1'b1, CMD_SAMPLE, S64_MAX - 5, 1, 1'b0, 0, ST_ERROR},
		'{1'b1, CMD_BAD, S64_MIN, 1, 1'b1, 64'sd0, ST_BADREAD},
		'{1'b1, CMD_SAMPLE, S64_MAX, 1, 1'b0, 0, ST_ERROR},
		'{1'b1, CMD_SAMPLE, S64_MIN, 1, 1'b1, S64_MIN, ST_TOLRST},
		'{1'b1, CMD_SAMPLE, -64'sd5, 1, 1'b1, -64'sd5, ST_FIRST},
		'{1'b1, CMD_SAMPLE, 64'sd0, 1, 1'b1, 64'sd0, ST_FIRST},
		'{1'b1, CMD_SAMPLE, 64'sd7, 1, 1'b1, 64'sd7, ST_FIRST},
		'{1'b1, CMD_SAMPLE, 64'sd1000007, 1, 1'b0, 0, ST_ERROR}
	};

	// receiver: random stalls, one long hold-off while the sender keeps going
	always @(posedge clk) begin
		if (hold_on && !hold_done) begin
			out_ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 34);
		end
	end

	always @(posedge clk) begin
		tdf_out_t want;
		if (out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$display("%0t: item with no expectation: %0d status %0d", $time,
					out_data.filtered_ns, out_data.status);
				fails++;
			end else begin
				want = pending.pop_front();
				if (out_data.filtered_ns !== want.filtered_ns) begin
					$display("%0t: filtered_ns expected %0d actual %0d", $time,
						want.filtered_ns, out_data.filtered_ns);
					fails++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, out_data.status);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		tdf_in_t it;
		tdf_out_t want;
		m_stamp = 0; m_err = 0; m_ratio = RATIO_W'(1) << FRAC; m_bad = 1'b0;
		c_en = 1'b0; c_period = PERIOD_W'(1000000); c_tol = TOL_W'(5000000);
		c_phase = PHASE_W'(10);
		c_gain = 48'd1000000000000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			if (table_rows[i].en != c_en) begin
				drain();
				reg_write(REG_ENABLED, 64'(table_rows[i].en));
			end
			it.cmd = table_rows[i].cmd;
			it.timestamp_ns = table_rows[i].ts;
			it.sample_count = CNT_W'(table_rows[i].cnt);
			want.filtered_ns = table_rows[i].want_ts;
			want.status = table_rows[i].want_st;
			offer(it, table_rows[i].typed, want);
		end

		// no idling here, plus the long receiver hold-off
		calm = 1'b1;
		set_filter(1'b1, 64'd1000000, 64'd5000000, 64'd10, 64'd1000000000000);
		hold_on = 1'b1;
		random_run(400);
		calm = 1'b0;
		set_filter(1'b1, 64'd1, 64'd0, 64'd1, 64'd1);
		random_run(250);
		set_filter(1'b1, 64'd1000000000, 64'hFF_FFFF_FFFF, 64'd65535, 64'hFFFF_FFFF_FFFF);
		random_run(300);
		set_filter(1'b0, 64'd1000, 64'd1000, 64'd3, 64'd1000);
		random_run(40);
		// zero step and zero divisors
		set_filter(1'b1, 64'd0, 64'd1000, 64'd0, 64'd0);
		random_run(250);
		set_filter(1'b1, 64'h3FFF_FFFF, 64'd200000, 64'd7, 64'd5000000000);
		random_run(150);
		set_filter(1'b1, 64'd33333, 64'd200000, 64'd7, 64'd5000000000);
		random_run(250);
		set_filter(1'b1, 64'($urandom_range(1, 5000000)), {$urandom_range(0, 255), $urandom},
			64'($urandom_range(1, 65535)), {$urandom_range(0, 65535), $urandom});
		random_run(300);

		drain();
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tdf_pkg.sv
hdl/tdf_mul.sv
hdl/tdf_div.sv
hdl/tdf_dp.sv
hdl/tdf_ctrl.sv
hdl/timestamp_drift_filter.sv
tb/timestamp_drift_filter_tb.sv
